[src/tkwt_pkg.sv]
package tkwt_pkg;

    localparam logic [2:0] ST_MERGED   = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FILTERED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DRAWN    = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    localparam int MIN_SHARED = 2;
    localparam logic [31:0] W_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [31:0] weight;
        logic        check_shared;
        logic [7:0]  count_a;
        logic [7:0]  count_b;
        logic [7:0]  count_c;
        logic [7:0]  count_d;
        logic [15:0] draw_fraction;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  entry_index;
        logic [47:0] total_weight;
        logic [7:0]  out_a;
        logic [7:0]  out_b;
        logic [7:0]  out_c;
        logic [7:0]  out_d;
    } rsp_item_t;

    // token control bits that walk the cell row
    typedef struct packed {
        logic valid;
        logic draw;
        logic done;
    } tok_ctl_t;

endpackage

[src/tkwt_cell.sv]
module tkwt_cell #(
    parameter int IDX        = 0,
    parameter int KEY_W      = 32,
    parameter int IDX_W      = 8,
    parameter int CNT_W      = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      count,
    input  logic                  wr_en,
    input  logic [KEY_W-1:0]      wr_key,
    input  logic [31:0]           wr_weight,
    input  tkwt_pkg::tok_ctl_t    ctl_in,
    input  logic [KEY_W-1:0]      key_in,
    input  logic [47:0]           tgt_in,
    input  logic [47:0]           acc_in,
    input  logic [IDX_W-1:0]      idx_in,
    output tkwt_pkg::tok_ctl_t    ctl_out,
    output logic [KEY_W-1:0]      key_out,
    output logic [47:0]           tgt_out,
    output logic [47:0]           acc_out,
    output logic [IDX_W-1:0]      idx_out
);

    logic [KEY_W-1:0]   key_reg;
    logic [31:0]        weight_reg;
    logic [31:0]        weight_next;
    tkwt_pkg::tok_ctl_t ctl_reg, ctl_next;
    logic [KEY_W-1:0]   tkey_reg, tkey_next;
    logic [47:0]        tgt_reg;
    logic [47:0]        acc_reg, acc_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               active;
    logic [32:0]        wsum;
    logic [47:0]        draw_acc;

    assign active   = ctl_in.valid && !ctl_in.done && (CNT_W'(IDX) < count);
    assign wsum     = {1'b0, weight_reg} + {1'b0, tgt_in[31:0]};
    assign draw_acc = acc_in + 48'(weight_reg);

    always_comb
    begin
        ctl_next    = ctl_in;
        tkey_next   = key_in;
        acc_next    = acc_in;
        idx_next    = idx_in;
        weight_next = weight_reg;
        if (active && !ctl_in.draw && key_reg == key_in)
        begin
            weight_next   = wsum[32] ? tkwt_pkg::W_MAX : wsum[31:0];
            acc_next      = 48'(weight_next - weight_reg);
            idx_next      = IDX_W'(IDX);
            ctl_next.done = 1'b1;
        end
        else if (active && ctl_in.draw)
        begin
            acc_next = draw_acc;
            if (tgt_in < draw_acc)
            begin
                ctl_next.done = 1'b1;
                idx_next      = IDX_W'(IDX);
                tkey_next     = key_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tkey_reg <= tkey_next;
        tgt_reg  <= tgt_in;
        acc_reg  <= acc_next;
        idx_reg  <= idx_next;
        if (wr_en)
        begin
            key_reg    <= wr_key;
            weight_reg <= wr_weight;
        end
        else
        begin
            weight_reg <= weight_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign key_out = tkey_reg;
    assign tgt_out = tgt_reg;
    assign acc_out = acc_reg;
    assign idx_out = idx_reg;

endmodule

[src/tuple_keyed_weight_table.sv]
// Channel | Signals                    | Moves
// req     | req_valid, req_ready, req  | one add or draw item in
// rsp     | rsp_valid, rsp_ready, rsp  | one result item out
// An add or a draw sends a token down the row of ENTRIES cells, one cell a cycle;
// a draw first scales its fraction by the total in the S_MUL and S_SUM states.
// A filtered add or a draw on an empty table sends no token and goes to S_DONE.
// req_ready is high only while idle; a result held in rsp does not block the walk.
// Reset clears the entry count, the total and all tokens; cell contents stay unknown.
module tuple_keyed_weight_table #(
    parameter int POPS       = 4,
    parameter int ENTRIES    = 256,
    parameter int COUNT_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tkwt_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tkwt_pkg::rsp_item_t rsp
);

    localparam int KEY_W = POPS * COUNT_BITS;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [47:0]         total_reg;
    tkwt_pkg::req_item_t item_reg;
    logic [KEY_W-1:0]    ikey_reg;
    logic                skip_reg;
    logic [39:0]         phi_reg, plo_reg;
    tkwt_pkg::tok_ctl_t  head_ctl_reg;
    logic [47:0]         head_tgt_reg;
    logic                res_done_reg;
    logic [KEY_W-1:0]    res_key_reg;
    logic [47:0]         res_acc_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic                rsp_valid_reg;
    tkwt_pkg::rsp_item_t rsp_reg, rsp_next;
    logic [CNT_W-1:0]    count_next;
    logic [47:0]         total_next;
    logic                wr_go;

    logic [KEY_W-1:0]    req_key;
    logic [3:0]          nz;
    logic                filt;
    logic [63:0]         prod;
    logic [48:0]         tsum;
    logic [7:0]          tup [4];

    tkwt_pkg::tok_ctl_t  lctl [ENTRIES+1];
    logic [KEY_W-1:0]    lkey [ENTRIES+1];
    logic [47:0]         ltgt [ENTRIES+1];
    logic [47:0]         lacc [ENTRIES+1];
    logic [IDX_W-1:0]    lidx [ENTRIES+1];

    genvar g;
    generate
        for (g = 0; g < POPS; g++)
        begin : g_key
            logic [15:0] c16;
            if (g == 0)
            begin : g0
                assign c16 = 16'(req.count_a);
            end
            else if (g == 1)
            begin : g1
                assign c16 = 16'(req.count_b);
            end
            else if (g == 2)
            begin : g2
                assign c16 = 16'(req.count_c);
            end
            else if (g == 3)
            begin : g3
                assign c16 = 16'(req.count_d);
            end
            else
            begin : gz
                assign c16 = 16'd0;
            end
            assign req_key[g*COUNT_BITS +: COUNT_BITS] = c16[COUNT_BITS-1:0];
        end

        for (g = 0; g < 4; g++)
        begin : g_tup
            if (g < POPS)
            begin : gp
                logic [15:0] k16;
                assign k16    = 16'(res_key_reg[g*COUNT_BITS +: COUNT_BITS]);
                assign tup[g] = k16[7:0];
            end
            else
            begin : gn
                assign tup[g] = 8'd0;
            end
        end

        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            tkwt_cell #(
                .IDX   (g),
                .KEY_W (KEY_W),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (count_reg),
                .wr_en     (wr_go && count_reg == CNT_W'(g)),
                .wr_key    (ikey_reg),
                .wr_weight (item_reg.weight),
                .ctl_in    (lctl[g]),
                .key_in    (lkey[g]),
                .tgt_in    (ltgt[g]),
                .acc_in    (lacc[g]),
                .idx_in    (lidx[g]),
                .ctl_out   (lctl[g+1]),
                .key_out   (lkey[g+1]),
                .tgt_out   (ltgt[g+1]),
                .acc_out   (lacc[g+1]),
                .idx_out   (lidx[g+1])
            );
        end
    endgenerate

    assign lctl[0] = head_ctl_reg;
    assign lkey[0] = ikey_reg;
    assign ltgt[0] = head_tgt_reg;
    assign lacc[0] = 48'd0;
    assign lidx[0] = '0;

    always_comb
    begin
        nz = 4'd0;
        for (int p = 0; p < POPS; p++)
        begin
            nz = nz + 4'(req_key[p*COUNT_BITS +: COUNT_BITS] != '0);
        end
    end

    assign filt = req.check_shared && 32'(nz) < tkwt_pkg::MIN_SHARED;

    assign prod = {phi_reg, 24'd0} + 64'(plo_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign wr_go     = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready) &&
                       !item_reg.action && !skip_reg && !res_done_reg &&
                       (count_reg != CNT_W'(ENTRIES));

    always_comb
    begin
        rsp_next   = '0;
        count_next = count_reg;
        total_next = total_reg;
        tsum       = 49'd0;
        if (item_reg.action)
        begin
            if (!skip_reg && res_done_reg)
            begin
                rsp_next.status      = tkwt_pkg::ST_DRAWN;
                rsp_next.entry_index = 8'(16'(res_idx_reg));
                rsp_next.out_a       = tup[0];
                rsp_next.out_b       = tup[1];
                rsp_next.out_c       = tup[2];
                rsp_next.out_d       = tup[3];
            end
            else
            begin
                rsp_next.status = tkwt_pkg::ST_NONE;
            end
        end
        else if (skip_reg)
        begin
            rsp_next.status = tkwt_pkg::ST_FILTERED;
        end
        else if (res_done_reg)
        begin
            rsp_next.status      = tkwt_pkg::ST_MERGED;
            rsp_next.entry_index = 8'(16'(res_idx_reg));
            tsum                 = {1'b0, total_reg} + {1'b0, res_acc_reg};
            total_next           = tsum[48] ? tkwt_pkg::T_MAX : tsum[47:0];
        end
        else if (count_reg == CNT_W'(ENTRIES))
        begin
            rsp_next.status = tkwt_pkg::ST_FULL;
        end
        else
        begin
            rsp_next.status      = tkwt_pkg::ST_INSERTED;
            rsp_next.entry_index = 8'(16'(count_reg));
            tsum                 = {1'b0, total_reg} + 49'(item_reg.weight);
            total_next           = tsum[48] ? tkwt_pkg::T_MAX : tsum[47:0];
            count_next           = count_reg + CNT_W'(1);
        end
        rsp_next.total_weight = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            head_ctl_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && req_valid && !req.action && !filt)
            begin
                head_ctl_reg <= '{valid: 1'b1, draw: 1'b0, done: 1'b0};
            end
            else if (state_reg == S_SUM)
            begin
                head_ctl_reg <= '{valid: 1'b1, draw: 1'b1, done: 1'b0};
            end
            else
            begin
                head_ctl_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req.action)
                        begin
                            state_reg <= (total_reg == 48'd0) ? S_DONE : S_MUL;
                        end
                        else if (filt)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (lctl[ENTRIES].valid)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        count_reg <= count_next;
                        total_reg <= total_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            item_reg     <= req;
            ikey_reg     <= req_key;
            skip_reg     <= req.action ? (total_reg == 48'd0) : filt;
            head_tgt_reg <= 48'(req.weight);
        end
        if (state_reg == S_MUL)
        begin
            phi_reg <= item_reg.draw_fraction * total_reg[47:24];
            plo_reg <= item_reg.draw_fraction * total_reg[23:0];
        end
        if (state_reg == S_SUM)
        begin
            head_tgt_reg <= prod[63:16];
        end
        if (state_reg == S_WALK && lctl[ENTRIES].valid)
        begin
            res_done_reg <= lctl[ENTRIES].done;
            res_key_reg  <= lkey[ENTRIES];
            res_acc_reg  <= lacc[ENTRIES];
            res_idx_reg  <= lidx[ENTRIES];
        end
        if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/tkwt_checker.sv]
module tkwt_props (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input tkwt_pkg::req_item_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input tkwt_pkg::rsp_item_t rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("req changed while waiting");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= tkwt_pkg::ST_NONE)
        else $error("bad status");

    a_tuple_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != tkwt_pkg::ST_DRAWN |->
        rsp.out_a == 8'd0 && rsp.out_b == 8'd0 && rsp.out_c == 8'd0 && rsp.out_d == 8'd0)
        else $error("tuple set without a draw");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == tkwt_pkg::ST_FILTERED ||
        rsp.status == tkwt_pkg::ST_FULL || rsp.status == tkwt_pkg::ST_NONE) |->
        rsp.entry_index == 8'd0)
        else $error("index set without an entry");

endmodule

bind tuple_keyed_weight_table tkwt_props u_tkwt_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
